// ===== hw/rtl/otq_pkg.sv =====
// Package for the ordered timer event queue.
// Holds the default sizes, operation and result codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package otq_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 48;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_CHANGE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	localparam logic KIND_FIRE  = 1'b0;
	localparam logic KIND_SCHED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_CHG1,
		ST_CHG2,
		ST_DUE,
		ST_FIND,
		ST_FIRE,
		ST_REP,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/ordered_timer_event_queue_top.sv =====
// Top level of the ordered timer event queue: sequencer, slot flags and output register.
// Uses otq_pkg, otq_store and otq_alu.
//
//   channel | signals                                            | direction
//   input   | in_valid in_stall op slot interval_ms periodic       | in
//           | start_now now_ms                                   |
//   output  | out_valid out_stall kind fired_slot delay_ms         | out
//           | pending last                                       |
//
// Add, cancel and change spend most of their time in the scan for the earliest deadline.
// A tick scans once to mark due slots, once per fired slot and once more to pick the earliest due
// slot, then once for the next deadline; every scan reads the slot memory once per slot through its single read port.
// Reset clears all armed and periodic flags; deadlines and intervals are written before use.
// A stalled output holds the sequencer on its next result; input is taken only when idle.
`timescale 1ns / 1ps

module ordered_timer_event_queue_top #(
	parameter int SLOTS     = otq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = otq_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] interval_ms,
	input  logic        periodic,
	input  logic        start_now,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  fired_slot,
	output logic [47:0] delay_ms,
	output logic        pending,
	output logic        last
);

	import otq_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int WW = TIME_BITS + 32;

	state_t state_q, state_d;

	op_t                 op_q;
	logic                slot_ok_q;
	logic [IW-1:0]       sidx_q;
	logic [31:0]         ival_q;
	logic                per_q;
	logic                snow_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] start_q;

	logic [SLOTS-1:0] armed_q, repeats_q, due_q;

	logic [CW-1:0]        cnt_q;
	logic                 v_s1;
	logic [IW-1:0]        idx_s1;
	logic                 bv_q;
	logic [IW-1:0]        bidx_q;
	logic [TIME_BITS-1:0] bdl_q;
	logic [31:0]          bper_q;

	logic                 we;
	logic [IW-1:0]        waddr, raddr;
	logic [WW-1:0]        wdata, rdata;
	logic [TIME_BITS-1:0] rd_dl;
	logic [31:0]          rd_per;

	logic [TIME_BITS-1:0] alu_a, alu_b, alu_sum, alu_diff;
	logic                 alu_lt, alu_eq;

	logic scan_issue, scan_done, room, in_scan, in_scan_d, take;
	logic [7:0]  slot8;
	logic [63:0] now64;
	logic [7:0]  bidx8;
	logic [63:0] dly64;

	assign slot8 = 8'(slot);
	assign now64 = 64'(now_ms);
	assign bidx8 = 8'(bidx_q);
	assign rd_dl  = rdata[TIME_BITS-1:0];
	assign rd_per = rdata[WW-1:TIME_BITS];

	assign in_stall   = state_q != ST_IDLE;
	assign take       = in_valid && !in_stall;
	assign room       = !out_valid || !out_stall;
	assign scan_issue = cnt_q < CW'(SLOTS);
	assign scan_done  = !scan_issue && !v_s1;
	assign in_scan    = state_q == ST_DUE || state_q == ST_FIND || state_q == ST_REP;
	assign in_scan_d  = state_d == ST_DUE || state_d == ST_FIND || state_d == ST_REP;

	otq_store #(.SLOTS(SLOTS), .WIDTH(WW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	otq_alu #(.TIME_BITS(TIME_BITS)) u_alu (
		.a       (alu_a),
		.b       (alu_b),
		.sum_sat (alu_sum),
		.diff    (alu_diff),
		.lt      (alu_lt),
		.eq      (alu_eq)
	);

	always_comb begin
		alu_a = now_q;
		alu_b = TIME_BITS'(ival_q);
		case (state_q)
			ST_CHG1: begin
				alu_a = rd_dl;
				alu_b = TIME_BITS'(rd_per);
			end
			ST_CHG2: begin
				alu_a = start_q;
				alu_b = TIME_BITS'(ival_q);
			end
			ST_DUE: begin
				alu_a = now_q;
				alu_b = rd_dl;
			end
			ST_FIND, ST_REP: begin
				alu_a = rd_dl;
				alu_b = bdl_q;
			end
			ST_FIRE: begin
				alu_a = now_q;
				alu_b = TIME_BITS'(bper_q);
			end
			ST_OUT: begin
				alu_a = bdl_q;
				alu_b = now_q;
			end
			default: begin
				alu_a = now_q;
				alu_b = TIME_BITS'(ival_q);
			end
		endcase
	end

	always_comb begin
		raddr = in_scan ? cnt_q[IW-1:0] : sidx_q;
		we    = 1'b0;
		waddr = sidx_q;
		wdata = {ival_q, alu_sum};
		case (state_q)
			ST_CMD: we = op_q == OP_ADD && slot_ok_q;
			ST_CHG2: we = 1'b1;
			ST_FIRE: begin
				waddr = bidx_q;
				wdata = {bper_q, alu_sum};
				we    = room && repeats_q[bidx_q];
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take) state_d = ST_CMD;
			ST_CMD: begin
				case (op_q)
					OP_TICK: state_d = ST_DUE;
					OP_CHANGE: state_d = slot_ok_q ? ST_CHG1 : ST_REP;
					default: state_d = ST_REP;
				endcase
			end
			ST_CHG1: state_d = (rd_per == ival_q && !snow_q) ? ST_REP : ST_CHG2;
			ST_CHG2: state_d = ST_REP;
			ST_DUE: if (scan_done) state_d = ST_FIND;
			ST_FIND: if (scan_done) state_d = bv_q ? ST_FIRE : ST_REP;
			ST_FIRE: if (room) state_d = ST_FIND;
			ST_REP: if (scan_done) state_d = ST_OUT;
			ST_OUT: if (room) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q      <= op_t'(op);
			slot_ok_q <= slot8 < 8'(SLOTS);
			sidx_q    <= slot8[IW-1:0];
			ival_q    <= interval_ms;
			per_q     <= periodic;
			snow_q    <= start_now;
			now_q     <= now64[TIME_BITS-1:0];
		end
		if (state_q == ST_CHG1) begin
			start_q <= snow_q ? now_q : (alu_lt ? '0 : alu_diff);
		end
		if (in_scan && v_s1) begin
			if ((state_q == ST_FIND && due_q[idx_s1] || state_q == ST_REP && armed_q[idx_s1])
			    && (!bv_q || alu_lt)) begin
				bidx_q <= idx_s1;
				bdl_q  <= rd_dl;
				bper_q <= rd_per;
			end
		end
		idx_s1 <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			bv_q      <= 1'b0;
			armed_q   <= '0;
			repeats_q <= '0;
			due_q     <= '0;
		end else begin
			if (in_scan_d && (state_d != state_q || !in_scan)) begin
				cnt_q <= '0;
				v_s1  <= 1'b0;
				bv_q  <= 1'b0;
			end else if (in_scan) begin
				v_s1 <= scan_issue;
				if (scan_issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (v_s1 && (state_q == ST_FIND && due_q[idx_s1]
				    || state_q == ST_REP && armed_q[idx_s1])) begin
					bv_q <= 1'b1;
				end
			end
			case (state_q)
				ST_CMD: begin
					if (slot_ok_q && op_q == OP_ADD) begin
						armed_q[sidx_q]   <= 1'b1;
						repeats_q[sidx_q] <= per_q;
					end else if (slot_ok_q && op_q == OP_CANCEL) begin
						armed_q[sidx_q] <= 1'b0;
					end
				end
				ST_CHG2: armed_q[sidx_q] <= 1'b1;
				ST_DUE: begin
					if (v_s1) begin
						due_q[idx_s1] <= armed_q[idx_s1] && !alu_lt;
					end
				end
				ST_FIRE: begin
					if (room) begin
						due_q[bidx_q] <= 1'b0;
						if (!repeats_q[bidx_q]) begin
							armed_q[bidx_q] <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign dly64 = 64'(alu_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_FIRE || state_q == ST_OUT) && room) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIRE && room) begin
			kind       <= KIND_FIRE;
			fired_slot <= bidx8[3:0];
			delay_ms   <= '0;
			pending    <= 1'b0;
			last       <= 1'b0;
		end else if (state_q == ST_OUT && room) begin
			kind       <= KIND_SCHED;
			fired_slot <= '0;
			delay_ms   <= (bv_q && !alu_lt && !alu_eq) ? dly64[47:0] : '0;
			pending    <= bv_q;
			last       <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_last_is_sched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == KIND_SCHED)))
		else $error("Last flag and result kind disagree.");
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FIRE |-> !pending && delay_ms == '0)
		else $error("Fire result carries schedule fields.");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Sequencer did not start on an accepted item.");
	a_due_subset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND |-> (due_q & ~armed_q) == '0)
		else $error("Due slot is not armed.");
`endif

endmodule

// ===== hw/rtl/otq_alu.sv =====
// Shared arithmetic and compare unit of the timer queue.
// Gives a saturating sum, a difference and the compare flags of two time values.
// No package dependency.
`timescale 1ns / 1ps

module otq_alu #(
	parameter int TIME_BITS = 48
) (
	input  logic [TIME_BITS-1:0] a,
	input  logic [TIME_BITS-1:0] b,
	output logic [TIME_BITS-1:0] sum_sat,
	output logic [TIME_BITS-1:0] diff,
	output logic                 lt,
	output logic                 eq
);

	logic [TIME_BITS:0] sum;

	assign sum     = {1'b0, a} + {1'b0, b};
	assign sum_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	assign diff    = a - b;
	assign lt      = a < b;
	assign eq      = a == b;

endmodule

// ===== hw/rtl/otq_store.sv =====
// Slot memory of the timer queue: one word per slot holding interval and deadline.
// One write port and one read port with registered read data. No package dependency.
`timescale 1ns / 1ps

module otq_store #(
	parameter int SLOTS = 16,
	parameter int WIDTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
